### hw/rtl/irpwd_pkg.sv
// shared types, constants and helpers of the ir pulse width decoder
// no dependencies
package irpwd_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BitIdxW = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;

  localparam int TimeW = 32;
  localparam int ByteW = 8;
  localparam int FrameW = 8;

  localparam logic [TimeW-1:0] StartupLo = 32'd24500;
  localparam logic [TimeW-1:0] StartupHi = 32'd26000;
  localparam logic [TimeW-1:0] ConfirmLo = 32'd1500;
  localparam logic [TimeW-1:0] ConfirmHi = 32'd1700;
  localparam logic [TimeW-1:0] FrameLo = 32'd34000;
  localparam logic [TimeW-1:0] FrameHi = 32'd36000;
  localparam logic [TimeW-1:0] Bit0Lo = 32'd300;
  localparam logic [TimeW-1:0] Bit0Hi = 32'd450;
  localparam logic [TimeW-1:0] Bit1Lo = 32'd1150;
  localparam logic [TimeW-1:0] Bit1Hi = 32'd1300;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW = 1;
  localparam int QueueCntW = 2;

  typedef enum logic [2:0] {
    CLS_STARTUP,
    CLS_CONFIRM,
    CLS_FRAME,
    CLS_BIT0,
    CLS_BIT1,
    CLS_BAD
  } pulse_class_t;

  typedef enum logic [2:0] {
    KIND_STARTUP = 3'd0,
    KIND_CONFIRM = 3'd1,
    KIND_FRAME   = 3'd2,
    KIND_BIT     = 3'd3,
    KIND_BAD     = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    STAGE_IDLE      = 2'd0,
    STAGE_STARTED   = 2'd1,
    STAGE_CONFIRMED = 2'd2
  } stage_t;

  // handshake between front and queue, queue and back
  typedef struct packed {
    logic         valid;
    pulse_class_t cls;
  } class_push_t;

  function automatic logic in_window(input logic [TimeW-1:0] d,
                                     input logic [TimeW-1:0] lo,
                                     input logic [TimeW-1:0] hi);
    return (d > lo) && (d < hi);
  endfunction

endpackage

### hw/rtl/irpwd_in_if.sv
// edge input channel of the ir pulse width decoder
// depends on irpwd_pkg
interface irpwd_in_if
  import irpwd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] edge_time;
  logic             rising_edge;

  modport source (output valid, output edge_time, output rising_edge, input ready);
  modport sink (input valid, input edge_time, input rising_edge, output ready);
endinterface

### hw/rtl/irpwd_out_if.sv
// event output channel of the ir pulse width decoder
// depends on irpwd_pkg
interface irpwd_out_if
  import irpwd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        event_kind;
  logic              bit_value;
  logic              byte_done;
  logic [ByteW-1:0]  byte_value;
  logic [FrameW-1:0] frame_number;
  logic [1:0]        sequence_stage;
  logic              bad_in_sequence;

  modport source (output valid, output event_kind, output bit_value, output byte_done,
                  output byte_value, output frame_number, output sequence_stage,
                  output bad_in_sequence, input ready);
  modport sink (input valid, input event_kind, input bit_value, input byte_done,
                input byte_value, input frame_number, input sequence_stage,
                input bad_in_sequence, output ready);
endinterface

### hw/rtl/irpwd_front.sv
// front end: takes edges, keeps the rise time and classifies each high pulse
// depends on irpwd_pkg and irpwd_in_if
module irpwd_front
  import irpwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  irpwd_in_if.sink          edges,
  output class_push_t       push,
  input  logic              push_ready
);

  logic [TimeW-1:0] last_rise;
  logic [TimeW-1:0] high_time;
  pulse_class_t     cls;

  assign edges.ready = push_ready;
  assign high_time = edges.edge_time - last_rise;

  always_comb begin
    if (in_window(high_time, StartupLo, StartupHi)) begin
      cls = CLS_STARTUP;
    end else if (in_window(high_time, ConfirmLo, ConfirmHi)) begin
      cls = CLS_CONFIRM;
    end else if (in_window(high_time, FrameLo, FrameHi)) begin
      cls = CLS_FRAME;
    end else if (in_window(high_time, Bit0Lo, Bit0Hi)) begin
      cls = CLS_BIT0;
    end else if (in_window(high_time, Bit1Lo, Bit1Hi)) begin
      cls = CLS_BIT1;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign push.valid = edges.valid && !edges.rising_edge;
  assign push.cls = cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rise <= '0;
    end else if (edges.valid && edges.ready && edges.rising_edge) begin
      last_rise <= edges.edge_time;
    end
  end

endmodule

### hw/rtl/irpwd_queue.sv
// short queue of pulse classes between front and back
// depends on irpwd_pkg
module irpwd_queue
  import irpwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  class_push_t push,
  output logic        push_ready,
  output class_push_t pop,
  input  logic        pop_ready
);

  pulse_class_t         entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != QueueCntW'(QueueDepth));
  assign pop.valid = (count != '0);
  assign pop.cls = entries[rd_ptr];
  assign do_push = push.valid && push_ready;
  assign do_pop = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/irpwd_back.sv
// back end: sequence state, frame count, byte assembly and the result register
// depends on irpwd_pkg and irpwd_out_if
module irpwd_back
  import irpwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  class_push_t pop,
  output logic        pop_ready,
  irpwd_out_if.source events
);

  stage_t             stage;
  stage_t             stage_next;
  logic [FrameW-1:0]  frame_count;
  logic [FrameW-1:0]  frame_count_next;
  logic [BitIdxW-1:0] bit_index;
  logic [BitIdxW-1:0] bit_index_next;
  logic [ByteW-1:0]   bit_shift;
  logic [ByteW-1:0]   bit_shift_next;

  event_kind_t        kind;
  logic               bitv;
  logic               done;
  logic               bad_seq;
  logic [BitIdxW:0]   idx_inc;
  logic [31:0]        idx32;
  logic               take;

  assign take = pop.valid && (!events.valid || events.ready);
  assign pop_ready = !events.valid || events.ready;
  assign idx32 = 32'(bit_index);
  assign idx_inc = {1'b0, bit_index} + 1'b1;

  always_comb begin
    stage_next       = stage;
    frame_count_next = frame_count;
    bit_index_next   = bit_index;
    bit_shift_next   = bit_shift;
    kind             = KIND_BAD;
    bitv             = 1'b0;
    done             = 1'b0;
    bad_seq          = 1'b0;
    unique case (pop.cls)
      CLS_STARTUP: begin
        kind       = KIND_STARTUP;
        stage_next = STAGE_STARTED;
      end
      CLS_CONFIRM: begin
        kind             = KIND_CONFIRM;
        frame_count_next = '0;
        bit_index_next   = '0;
        stage_next       = (stage == STAGE_STARTED) ? STAGE_CONFIRMED : STAGE_IDLE;
      end
      CLS_FRAME: begin
        kind             = KIND_FRAME;
        frame_count_next = frame_count + 1'b1;
        bit_index_next   = '0;
      end
      CLS_BIT0, CLS_BIT1: begin
        kind = KIND_BIT;
        bitv = (pop.cls == CLS_BIT1);
        // positions past the byte are counted but dropped
        if (idx32 < 32'(ByteW)) begin
          bit_shift_next[idx32[2:0]] = bitv;
        end
        if (32'(idx_inc) >= 32'(BITS_PER_BYTE)) begin
          done           = 1'b1;
          bit_index_next = '0;
        end else begin
          bit_index_next = idx_inc[BitIdxW-1:0];
        end
      end
      default: begin
        kind             = KIND_BAD;
        bad_seq          = (stage != STAGE_IDLE);
        stage_next       = STAGE_IDLE;
        frame_count_next = '0;
        bit_index_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= STAGE_IDLE;
      frame_count <= '0;
      bit_index   <= '0;
      bit_shift   <= '0;
      events.valid <= 1'b0;
    end else begin
      if (take) begin
        stage       <= stage_next;
        frame_count <= frame_count_next;
        bit_index   <= bit_index_next;
        bit_shift   <= bit_shift_next;
        events.valid <= 1'b1;
      end else if (events.ready) begin
        events.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      events.event_kind      <= kind;
      events.bit_value       <= bitv;
      events.byte_done       <= done;
      events.byte_value      <= done ? bit_shift_next : '0;
      events.frame_number    <= frame_count_next;
      events.sequence_stage  <= stage_next;
      events.bad_in_sequence <= bad_seq;
    end
  end

endmodule

### hw/rtl/ir_pulse_width_decoder_top.sv
// Decodes timestamped edges of an infrared receiver line into pulse events.
// A rising edge only records its time; each falling edge yields one event
// that classifies the high time (startup, confirmation, new frame, data bit
// or bad data) and reports the sequence stage, frame number and, every
// BITS_PER_BYTE data bits, the assembled byte (first bit in bit 0). One edge
// is taken every cycle while the queue has room: the front end classifies an
// edge in the cycle it is accepted, a two-entry queue feeds the back end, and
// the back end updates its state and loads the result register in the cycle
// it takes a class from the queue, so an event passes from its falling edge
// through a queue entry and then the result register, and is held there for
// as long as the output stalls. With the queue and the result register full the input stalls.
// depends on irpwd_pkg, irpwd_in_if, irpwd_out_if, irpwd_front, irpwd_queue,
// irpwd_back
module ir_pulse_width_decoder_top
  import irpwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  irpwd_in_if.sink    edges,
  irpwd_out_if.source events
);

  class_push_t push;
  logic        push_ready;
  class_push_t pop;
  logic        pop_ready;

  irpwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .edges      (edges),
    .push       (push),
    .push_ready (push_ready)
  );

  irpwd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  irpwd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_ready (pop_ready),
    .events    (events)
  );

endmodule
